// File: design/sbm_pkg.sv
`timescale 1ns / 1ps

package sbm_pkg;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    localparam int unsigned CTRL_W  = 5;
    localparam int unsigned BANK_W  = 4;
    localparam int unsigned LIMIT_W = 30;
    localparam int unsigned TIMER_W = LIMIT_W + 1;

    // control register selects (address bits 14:13)
    localparam logic [1:0] REG_CTRL = 2'd0;
    localparam logic [1:0] REG_CHR0 = 2'd1;
    localparam logic [1:0] REG_CHR1 = 2'd2;
    localparam logic [1:0] REG_PRG  = 2'd3;

    // program mode, control register 0 bits 3:2
    localparam logic [1:0] PRG_32K      = 2'b00;
    localparam logic [1:0] PRG_32K_ALT  = 2'b01;
    localparam logic [1:0] PRG_FIX_LOW  = 2'b10;
    localparam logic [1:0] PRG_FIX_HIGH = 2'b11;

    localparam int unsigned R1_PRG_HI_BIT  = 3;
    localparam int unsigned R1_IRQ_OFF_BIT = 4;

    localparam logic [CTRL_W-1:0] CTRL_MODE_SET = 5'h0C;
    localparam logic [2:0]        SHIFT_LAST    = 3'd4;
    localparam logic [1:0]        WARMUP_DONE   = 2'd2;

    localparam logic [CTRL_W-1:0] CTRL_RESET [4] = '{5'h0C, 5'h00, 5'h00, 5'h10};
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 30'd537039286;

    localparam logic [BANK_W-1:0] BANK_LOW_RESET  = 4'h0;
    localparam logic [BANK_W-1:0] BANK_HIGH_RESET = 4'h1;
    localparam logic [BANK_W-1:0] BANK_UPPER_BASE = 4'h8;
    localparam logic [BANK_W-1:0] BANK_LAST       = 4'hF;

    localparam logic [3:0] MIRROR_MAP [4] = '{4'h0, 4'hF, 4'hA, 4'hC};

    typedef struct packed {
        logic [BANK_W-1:0] low;
        logic [BANK_W-1:0] high;
    } t_banks;

    typedef struct packed {
        logic [BANK_W-1:0] bank_low;
        logic [BANK_W-1:0] bank_high;
        logic [3:0]        mirror_map;
        logic              irq_enabled;
    } t_map;

    typedef struct packed {
        logic tick;
        logic irq_on;
        logic clear;
    } t_timer_ctl;

    typedef struct packed {
        logic [BANK_W-1:0] bank_low;
        logic [BANK_W-1:0] bank_high;
        logic [3:0]        mirror_map;
        logic              irq_enabled;
        logic              irq_fire;
    } t_result;

    function automatic t_banks bank_map(
        input logic [CTRL_W-1:0] r0,
        input logic [CTRL_W-1:0] r1,
        input logic [CTRL_W-1:0] r3
    );
        t_banks b;
        b.low  = BANK_LOW_RESET;
        b.high = BANK_HIGH_RESET;
        if (r1[R1_PRG_HI_BIT]) begin
            case (r0[3:2]) inside
                PRG_FIX_LOW: begin
                    b.low  = BANK_UPPER_BASE;
                    b.high = BANK_UPPER_BASE + {1'b0, r3[2:0]};
                end
                PRG_FIX_HIGH: begin
                    b.low  = BANK_UPPER_BASE + {1'b0, r3[2:0]};
                    b.high = BANK_LAST;
                end
                PRG_32K, PRG_32K_ALT: begin
                    b.low  = BANK_UPPER_BASE + {1'b0, r3[2:1], 1'b0};
                    b.high = {b.low[BANK_W-1:1], 1'b1};
                end
                default: begin
                    b.low  = BANK_LOW_RESET;
                    b.high = BANK_HIGH_RESET;
                end
            endcase
        end else begin
            b.low  = {1'b0, r1[2:1], 1'b0};
            b.high = {1'b0, r1[2:1], 1'b1};
        end
        return b;
    endfunction

endpackage

// File: design/sbm_core.sv
`timescale 1ns / 1ps

module sbm_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_command,
    input  logic [14:0]            i_address,
    input  logic [7:0]             i_data,
    output sbm_pkg::t_map          o_map,
    output sbm_pkg::t_timer_ctl    o_timer_ctl
);

    logic [sbm_pkg::CTRL_W-1:0] r_latch, n_latch;
    logic [2:0]                 r_count, n_count;
    logic [sbm_pkg::CTRL_W-1:0] r_regs [4];
    logic [sbm_pkg::CTRL_W-1:0] n_regs [4];
    logic [1:0]                 r_warm, n_warm;
    logic [sbm_pkg::BANK_W-1:0] r_low, n_low;
    logic [sbm_pkg::BANK_W-1:0] r_high, n_high;
    logic                       r_irq_on, n_irq_on;
    logic                       n_clear;
    logic                       is_write;
    logic [1:0]                 sel;
    logic [sbm_pkg::CTRL_W-1:0] shifted;
    sbm_pkg::t_banks            banks;

    assign is_write = i_accept && (sbm_pkg::t_cmd'(i_command) == sbm_pkg::CMD_WRITE);
    assign sel      = i_address[14:13];
    assign shifted  = r_latch | (5'(i_data[0]) << r_count);
    assign banks    = sbm_pkg::bank_map(n_regs[sbm_pkg::REG_CTRL], n_regs[sbm_pkg::REG_CHR0],
                                        n_regs[sbm_pkg::REG_PRG]);

    always_comb begin
        n_latch  = r_latch;
        n_count  = r_count;
        n_regs   = r_regs;
        n_warm   = r_warm;
        n_low    = r_low;
        n_high   = r_high;
        n_irq_on = r_irq_on;
        n_clear  = 1'b0;
        if (is_write) begin
            if (i_data[7]) begin
                n_latch = '0;
                n_count = '0;
                if (sel == sbm_pkg::REG_CTRL) begin
                    n_regs[sbm_pkg::REG_CTRL] = r_regs[sbm_pkg::REG_CTRL] | sbm_pkg::CTRL_MODE_SET;
                end
            end else if (r_count == sbm_pkg::SHIFT_LAST) begin
                n_regs[sel] = shifted;
                n_latch     = '0;
                n_count     = '0;
            end else begin
                n_latch = shifted;
                n_count = r_count + 3'd1;
            end
            if (r_warm != sbm_pkg::WARMUP_DONE) begin
                n_warm = r_warm + 2'd1;
            end else begin
                n_low    = banks.low;
                n_high   = banks.high;
                n_irq_on = !n_regs[sbm_pkg::REG_CHR0][sbm_pkg::R1_IRQ_OFF_BIT];
                n_clear  = !n_irq_on;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch  <= '0;
            r_count  <= '0;
            r_regs   <= sbm_pkg::CTRL_RESET;
            r_warm   <= '0;
            r_low    <= sbm_pkg::BANK_LOW_RESET;
            r_high   <= sbm_pkg::BANK_HIGH_RESET;
            r_irq_on <= 1'b0;
        end else begin
            r_latch  <= n_latch;
            r_count  <= n_count;
            r_regs   <= n_regs;
            r_warm   <= n_warm;
            r_low    <= n_low;
            r_high   <= n_high;
            r_irq_on <= n_irq_on;
        end
    end

    assign o_map.bank_low    = n_low;
    assign o_map.bank_high   = n_high;
    assign o_map.mirror_map  = sbm_pkg::MIRROR_MAP[n_regs[sbm_pkg::REG_CTRL][1:0]];
    assign o_map.irq_enabled = n_irq_on;

    assign o_timer_ctl.tick   = i_accept && (sbm_pkg::t_cmd'(i_command) == sbm_pkg::CMD_TICK);
    assign o_timer_ctl.irq_on = r_irq_on;
    assign o_timer_ctl.clear  = n_clear;

    // banks frozen during warm-up
    a_warmup_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_write && r_warm != sbm_pkg::WARMUP_DONE) |=> ($stable(r_low) && $stable(r_high)))
        else $error("bank moved during warm-up");

    a_port_reset_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_write && i_data[7] && sel == sbm_pkg::REG_CTRL)
            |=> (r_regs[sbm_pkg::REG_CTRL][3:2] == 2'b11 && r_count == 3'd0))
        else $error("port reset did not set program mode");

endmodule

// File: design/sbm_timer.sv
`timescale 1ns / 1ps

module sbm_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [sbm_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    input  sbm_pkg::t_timer_ctl         i_ctl,
    input  logic [7:0]                  i_cycles,
    output logic                        o_fire
);

    logic [sbm_pkg::LIMIT_W-1:0] r_limit;
    logic [sbm_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic [sbm_pkg::TIMER_W-1:0] sum;
    logic                        run;

    assign run    = i_ctl.tick && i_ctl.irq_on;
    assign sum    = r_timer + sbm_pkg::TIMER_W'(i_cycles);
    assign o_fire = run && (sum >= sbm_pkg::TIMER_W'(r_limit));

    always_comb begin
        n_timer = r_timer;
        if (i_ctl.clear || o_fire) begin
            n_timer = '0;
        end else if (run) begin
            n_timer = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= sbm_pkg::LIMIT_RESET;
            r_timer <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_timer <= n_timer;
        end
    end

    a_fire_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire |=> (r_timer == '0))
        else $error("timer not cleared after fire");

    a_timer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (run && !o_fire) |=> (r_timer < sbm_pkg::TIMER_W'(r_limit) || $past(i_cfg_wr_en)))
        else $error("timer left at or above limit");

endmodule

// File: design/sbm_outbuf.sv
`timescale 1ns / 1ps

module sbm_outbuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sbm_pkg::t_result i_word,
    input  logic             i_out_stall,
    output logic             o_full,
    output logic             o_valid,
    output sbm_pkg::t_result o_word
);

    logic             r_main_valid;
    logic             r_skid_valid;
    sbm_pkg::t_result r_main;
    sbm_pkg::t_result r_skid;
    logic             take;

    assign take    = r_main_valid && !i_out_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_word  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_main <= r_skid_valid ? r_skid : i_word;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid <= i_word;
            end else begin
                r_main <= i_word;
            end
        end
    end

endmodule

// File: design/serial_bank_mapper_with_irq_timer_unit.sv
`timescale 1ns / 1ps

// Serial-port bank mapper with event timer.
// Input channel: i_in_valid / o_in_stall carries one word per item, either a
// program-space write (i_command = 0, i_address, i_data) or a cycle tick
// (i_command = 1, i_cycles). Output channel: o_out_valid / i_out_stall
// carries one result word per input word, in order: the bank numbers,
// mirroring map and IRQ enable after that item, plus o_irq_fire.
// The mapper state and the result are both computed in the cycle of
// acceptance and the result is registered. Throughput is one word per
// cycle while o_in_stall is low.
// The result register has a one-word skid entry beside it; o_in_stall is
// raised only when both entries are held because the receiver stalls, and
// drops the cycle after a word is taken.
// The timer limit is written through i_cfg_wr_en / i_cfg_wr_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Synchronous reset (i_rst_n low) empties the buffer and restores the
// control registers, banks 0/1, IRQ off, timer zero and the default limit.
module serial_bank_mapper_with_irq_timer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [29:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [14:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [7:0]  i_cycles,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_bank_low,
    output logic [3:0]  o_bank_high,
    output logic [3:0]  o_mirror_map,
    output logic        o_irq_enabled,
    output logic        o_irq_fire
);

    logic                accept;
    logic                fire;
    sbm_pkg::t_map       map;
    sbm_pkg::t_timer_ctl timer_ctl;
    sbm_pkg::t_result    result;
    sbm_pkg::t_result    out_word;

    assign accept = i_in_valid && !o_in_stall;

    sbm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_address   (i_address),
        .i_data      (i_data),
        .o_map       (map),
        .o_timer_ctl (timer_ctl)
    );

    sbm_timer u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctl         (timer_ctl),
        .i_cycles      (i_cycles),
        .o_fire        (fire)
    );

    assign result.bank_low    = map.bank_low;
    assign result.bank_high   = map.bank_high;
    assign result.mirror_map  = map.mirror_map;
    assign result.irq_enabled = map.irq_enabled;
    assign result.irq_fire    = fire;

    sbm_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_word      (result),
        .i_out_stall (i_out_stall),
        .o_full      (o_in_stall),
        .o_valid     (o_out_valid),
        .o_word      (out_word)
    );

    assign o_bank_low    = out_word.bank_low;
    assign o_bank_high   = out_word.bank_high;
    assign o_mirror_map  = out_word.mirror_map;
    assign o_irq_enabled = out_word.irq_enabled;
    assign o_irq_fire    = out_word.irq_fire;

    a_fire_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_irq_fire) |-> o_irq_enabled)
        else $error("irq fire with irq disabled");

endmodule
